// ===== design/wfct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wfct_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int DIST_W     = 10;
    localparam int TURN_W     = 16;

    localparam logic [DIST_W-1:0] NO_ECHO_CM     = 10'd400;
    localparam logic [1:0]        CONFIRM_FRAMES = 2'd2;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_ECHO       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_CM        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_DIST     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_GAP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_MS        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_LOW_DUTY  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_HIGH_DUTY = 3'd7;

    typedef enum logic [1:0] {
        MODE_NEAR   = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_TURN_L = 2'd2,
        MODE_TURN_R = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ACT_HOLD    = 3'd0,
        ACT_STOP    = 3'd1,
        ACT_FORWARD = 3'd2,
        ACT_STEER_L = 3'd3,
        ACT_STEER_R = 3'd4,
        ACT_TURN_L  = 3'd5,
        ACT_TURN_R  = 3'd6
    } action_t;

    typedef struct packed {
        logic [DIST_W-1:0] min_echo;
        logic [DIST_W-1:0] near_cm;
        logic [DIST_W-1:0] clear_dist;
        logic [DIST_W-1:0] dead_zone;
        logic [DIST_W-1:0] corner_gap;
        logic [TURN_W-1:0] turn_ms;
        logic [DIST_W-1:0] turn_low_duty;
        logic [DIST_W-1:0] turn_high_duty;
    } cfg_t;

    typedef struct packed {
        mode_t             mode;
        logic [1:0]        near_count;
        logic [1:0]        clear_count;
        logic              cruise_started;
        logic [TURN_W-1:0] turn_remaining;
    } ctl_state_t;

    typedef struct packed {
        action_t           action;
        logic              speed_init;
        logic              left_reverse;
        logic              right_reverse;
        logic [DIST_W-1:0] left_duty;
        logic [DIST_W-1:0] right_duty;
        mode_t             mode_now;
    } result_t;

endpackage

`default_nettype wire

// ===== design/wfct_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wfct_core (
    input  wire  wfct_pkg::cfg_t       cfg,
    input  wire  wfct_pkg::ctl_state_t state_cur,
    input  wire                        cmd,
    input  wire  [9:0]                 left_cm,
    input  wire  [9:0]                 right_cm,
    input  wire  [9:0]                 center_cm,
    output wfct_pkg::ctl_state_t       state_next,
    output wfct_pkg::result_t          result
);
    import wfct_pkg::*;

    logic [DIST_W-1:0]  center_eff;
    logic signed [10:0] diff;
    logic signed [10:0] band;
    logic signed [10:0] corner;
    logic               is_turn;

    assign center_eff = (center_cm < cfg.min_echo) ? NO_ECHO_CM : center_cm;
    assign diff       = $signed({1'b0, left_cm}) - $signed({1'b0, right_cm});
    assign band       = $signed({1'b0, cfg.dead_zone});
    assign corner     = $signed({1'b0, cfg.corner_gap});
    assign is_turn    = (state_cur.mode == MODE_TURN_L) || (state_cur.mode == MODE_TURN_R);

    always_comb
    begin
        ctl_state_t st;
        st     = state_cur;
        result = '{action: ACT_STOP, speed_init: 1'b0, left_reverse: 1'b0,
                   right_reverse: 1'b0, left_duty: '0, right_duty: '0,
                   mode_now: MODE_NEAR};

        if (cmd == CMD_TICK)
        begin
            if (st.turn_remaining != '0)
            begin
                st.turn_remaining = st.turn_remaining - 16'd1;
            end
        end
        else if (is_turn && (st.turn_remaining != '0))
        begin
            result.action = ACT_HOLD;
        end
        else
        begin
            if (is_turn)
            begin
                st.mode           = MODE_NEAR;
                st.cruise_started = 1'b0;
                st.near_count     = '0;
                st.clear_count    = '0;
            end

            if (center_eff >= cfg.clear_dist)
            begin
                if (st.clear_count < CONFIRM_FRAMES)
                begin
                    st.clear_count = st.clear_count + 2'd1;
                end
                st.near_count = '0;
            end
            else if (center_eff <= cfg.near_cm)
            begin
                if (st.near_count < CONFIRM_FRAMES)
                begin
                    st.near_count = st.near_count + 2'd1;
                end
                st.clear_count = '0;
            end
            else
            begin
                st.clear_count = '0;
                st.near_count  = '0;
            end

            if (st.clear_count >= CONFIRM_FRAMES)
            begin
                st.mode = MODE_CLEAR;
            end
            if (st.near_count >= CONFIRM_FRAMES)
            begin
                st.mode = MODE_NEAR;
            end

            if (st.mode == MODE_CLEAR)
            begin
                result.speed_init = !st.cruise_started;
                st.cruise_started = 1'b1;
                if (diff > band)
                begin
                    result.action = ACT_STEER_L;
                end
                else if (diff < -band)
                begin
                    result.action = ACT_STEER_R;
                end
                else
                begin
                    result.action = ACT_FORWARD;
                end
            end
            else
            begin
                st.cruise_started = 1'b0;
                if (diff >= corner)
                begin
                    result.action       = ACT_TURN_L;
                    result.left_reverse = 1'b1;
                    result.left_duty    = cfg.turn_low_duty;
                    result.right_duty   = cfg.turn_high_duty;
                    st.turn_remaining   = cfg.turn_ms;
                    st.mode             = MODE_TURN_L;
                end
                else if (diff <= -corner)
                begin
                    result.action        = ACT_TURN_R;
                    result.right_reverse = 1'b1;
                    result.left_duty     = cfg.turn_high_duty;
                    result.right_duty    = cfg.turn_low_duty;
                    st.turn_remaining    = cfg.turn_ms;
                    st.mode              = MODE_TURN_R;
                end
                else
                begin
                    result.action = ACT_STOP;
                end
            end
        end

        result.mode_now = st.mode;
        state_next      = st;
    end

endmodule

`default_nettype wire

// ===== design/wall_follow_corner_turn_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A frame transaction goes from the input register to the result register, which
// shows its command at the outputs; out_stall can hold it. Ticks give no result.
// Throughput: one transaction per cycle while the output is not stalled, set by the single decision stage.
// Reset clears the mode, counters, turn timer and valid flags, and loads
// the default thresholds, turn length and turn duties.

module wall_follow_corner_turn_fsm (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire                                 cmd,
    input  wire  [9:0]                          left_cm,
    input  wire  [9:0]                          right_cm,
    input  wire  [9:0]                          center_cm,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic [2:0]                          action,
    output logic                                speed_init,
    output logic                                left_reverse,
    output logic                                right_reverse,
    output logic [9:0]                          left_duty,
    output logic [9:0]                          right_duty,
    output logic [1:0]                          mode_now,
    input  wire                                 cfg_we,
    input  wire  [wfct_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [wfct_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import wfct_pkg::*;

    cfg_t              cfg_reg;
    ctl_state_t        st_reg;
    ctl_state_t        st_next;
    result_t           res_reg;
    result_t           res_next;
    logic              s1_valid_reg;
    logic              s1_cmd_reg;
    logic [DIST_W-1:0] s1_left_reg;
    logic [DIST_W-1:0] s1_right_reg;
    logic [DIST_W-1:0] s1_center_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              s1_advance;
    logic              in_accept;

    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && ((s1_cmd_reg == CMD_TICK) || out_free);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    wfct_core u_core (
        .cfg        (cfg_reg),
        .state_cur  (st_reg),
        .cmd        (s1_cmd_reg),
        .left_cm    (s1_left_reg),
        .right_cm   (s1_right_reg),
        .center_cm  (s1_center_reg),
        .state_next (st_next),
        .result     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{min_echo: 10'd5, near_cm: 10'd10, clear_dist: 10'd150,
                         dead_zone: 10'd5, corner_gap: 10'd15,
                         turn_ms: 16'd350, turn_low_duty: 10'd550,
                         turn_high_duty: 10'd750};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_ECHO:       cfg_reg.min_echo       <= cfg_data[DIST_W-1:0];
                REG_NEAR_CM:        cfg_reg.near_cm        <= cfg_data[DIST_W-1:0];
                REG_CLEAR_DIST:     cfg_reg.clear_dist     <= cfg_data[DIST_W-1:0];
                REG_DEAD_ZONE:      cfg_reg.dead_zone      <= cfg_data[DIST_W-1:0];
                REG_CORNER_GAP:     cfg_reg.corner_gap     <= cfg_data[DIST_W-1:0];
                REG_TURN_MS:        cfg_reg.turn_ms        <= cfg_data[TURN_W-1:0];
                REG_TURN_LOW_DUTY:  cfg_reg.turn_low_duty  <= cfg_data[DIST_W-1:0];
                REG_TURN_HIGH_DUTY: cfg_reg.turn_high_duty <= cfg_data[DIST_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '{mode: MODE_NEAR, near_count: 2'd0, clear_count: 2'd0,
                               cruise_started: 1'b0, turn_remaining: 16'd0};
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                st_reg <= st_next;
            end

            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance && (s1_cmd_reg == CMD_FRAME))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg    <= cmd;
            s1_left_reg   <= left_cm;
            s1_right_reg  <= right_cm;
            s1_center_reg <= center_cm;
        end
        if (s1_advance && (s1_cmd_reg == CMD_FRAME))
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign action        = res_reg.action;
    assign speed_init    = res_reg.speed_init;
    assign left_reverse  = res_reg.left_reverse;
    assign right_reverse = res_reg.right_reverse;
    assign left_duty     = res_reg.left_duty;
    assign right_duty    = res_reg.right_duty;
    assign mode_now      = res_reg.mode_now;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("Input stalled with an empty input register.");

    a_turn_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action != ACT_TURN_L) && (action != ACT_TURN_R))
        |-> ((left_duty == '0) && (right_duty == '0) && !left_reverse && !right_reverse))
        else $error("Turn fields set on a command that does not start a turn.");

    a_hold_in_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action == ACT_HOLD))
        |-> ((mode_now == MODE_TURN_L) || (mode_now == MODE_TURN_R)))
        else $error("Hold command outside a turn mode.");

    a_turn_start_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action == ACT_TURN_L)) |-> (mode_now == MODE_TURN_L))
        else $error("Left turn started without entering the left turn mode.");

endmodule

`default_nettype wire
